>>> sv/assert_macros.svh
// assertion helpers shared by the mixer modules
// each macro expects clk and rst to be visible in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CSM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("csm assertion failed");

// implication whose consequent is checked in the following cycle
`define CSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csm assertion failed");

`endif

>>> sv/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// shared constants, stage payload type and helpers of the crosspoint mixer
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int PORT_COUNT  = 8;
  localparam int BUS_COUNT   = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int MASK_BITS   = 4;
  localparam int CFG_BITS    = 64;
  localparam int CFG_IDX_BITS = 2;

  // exact product of a signed sample and an unsigned gain
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
  // room for all ports plus the rounding offset
  localparam int ACC_BITS  = PROD_BITS + $clog2(PORT_COUNT + 1) + 1;
  localparam int Q_BITS    = ACC_BITS - GAIN_FRAC;

  localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (GAIN_FRAC - 1);

  localparam logic signed [Q_BITS-1:0] SAT_HI = Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_BITS-1:0] SAT_LO = -SAT_HI - Q_BITS'(1);
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = SAT_HI[SAMPLE_BITS-1:0];
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = SAT_LO[SAMPLE_BITS-1:0];

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BUS_MASKS  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_GAINS_LOW  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_GAINS_HIGH = CFG_IDX_BITS'(2);

  localparam logic [31:0]         BUS_MASKS_RESET = 32'h1111_1111;
  localparam logic [CFG_BITS-1:0] GAINS_RESET     = 64'h1000_1000_1000_1000;

  // payload handed from one cell to the next
  typedef struct packed {
    logic [PORT_COUNT-1:0][SAMPLE_BITS-1:0] samples;
    logic [BUS_COUNT-1:0][ACC_BITS-1:0]     acc;
    logic [PROD_BITS-1:0]                   prod;
    logic [BUS_COUNT-1:0]                   prod_mask;
    logic                                   block_end;
  } csm_stage_t;

  // sign-extend a product to accumulator width
  function automatic logic [ACC_BITS-1:0] ext_prod(input logic [PROD_BITS-1:0] p);
    ext_prod = {{(ACC_BITS - PROD_BITS){p[PROD_BITS-1]}}, p};
  endfunction

endpackage

>>> sv/csm_cell.sv
// ----------------------------------------------------------------------------
// csm_cell
// one port cell: forms this port's product, adds the upstream product
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csm_cell import csm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   valid_in,
  input  csm_stage_t             stage_in,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [GAIN_BITS-1:0]   gain,
  input  logic [BUS_COUNT-1:0]   mask,
  output logic                   valid_out,
  output csm_stage_t             stage_out
);

  logic signed [PROD_BITS-1:0] prod_next;
  csm_stage_t                  stage_next;

  always_comb begin
    prod_next = '0;
    if (mask != '0) begin
      prod_next = $signed(sample) * $signed({1'b0, gain});
    end
    stage_next           = stage_in;
    stage_next.prod      = prod_next;
    stage_next.prod_mask = mask;
    for (int b = 0; b < BUS_COUNT; b++) begin
      if (stage_in.prod_mask[b]) begin
        stage_next.acc[b] = stage_in.acc[b] + ext_prod(stage_in.prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_out <= stage_next;
    end
  end

  // a port with an empty mask must not carry a product
  `CSM_ASSERT_NEXT(empty_mask_a, adv && (mask == '0), stage_out.prod == '0)

endmodule

>>> sv/csm_sat.sv
// ----------------------------------------------------------------------------
// csm_sat
// last cell: adds the final product, rounds to q1.23, saturates, registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csm_sat import csm_pkg::*; (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 valid_in,
  input  csm_stage_t                           stage_in,
  output logic                                 valid_out,
  output logic [BUS_COUNT-1:0][SAMPLE_BITS-1:0] bus_val,
  output logic [BUS_COUNT-1:0]                 clip,
  output logic                                 block_end
);

  logic [BUS_COUNT-1:0][ACC_BITS-1:0]    sum;
  logic signed [BUS_COUNT-1:0][Q_BITS-1:0] q;
  logic [BUS_COUNT-1:0][SAMPLE_BITS-1:0] bus_next;
  logic [BUS_COUNT-1:0]                  clip_next;

  always_comb begin
    for (int b = 0; b < BUS_COUNT; b++) begin
      sum[b] = stage_in.acc[b];
      if (stage_in.prod_mask[b]) begin
        sum[b] = stage_in.acc[b] + ext_prod(stage_in.prod);
      end
      // rounding offset already sits in the sum, so floor by a plain shift
      q[b] = sum[b][ACC_BITS-1:GAIN_FRAC];
      clip_next[b] = 1'b0;
      bus_next[b]  = q[b][SAMPLE_BITS-1:0];
      if ($signed(q[b]) > SAT_HI) begin
        bus_next[b]  = SAT_MAX;
        clip_next[b] = 1'b1;
      end else if ($signed(q[b]) < SAT_LO) begin
        bus_next[b]  = SAT_MIN;
        clip_next[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_val   <= bus_next;
      clip      <= clip_next;
      block_end <= stage_in.block_end;
    end
  end

  // a clipped bus holds one of the two limits
  for (genvar b = 0; b < BUS_COUNT; b++) begin : g_chk
    `CSM_ASSERT(clip_limit_a, valid_out && clip[b] |-> (bus_val[b] == SAT_MAX) || (bus_val[b] == SAT_MIN))
  end

endmodule

>>> sv/crosspoint_sum_mixer_core.sv
// ----------------------------------------------------------------------------
// crosspoint_sum_mixer_core
// eight-port, four-bus crosspoint summing mixer built as a chain of port cells
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  sample    in         sample_valid/sample_stall sample_port0..7, block_end_in
//  bus       out        bus_valid/bus_stall       bus_one..four, clip_flags,
//                                                 block_end_out
//  cfg       in         cfg_write                 cfg_index, cfg_data
//
//  one frame per cycle sustained while bus_stall stays low; each frame passes
//  one register per port cell plus the round/saturate output register
//  each cell has one multiplier and one add per bus, which sets the clock rate
//  rst (synchronous) empties the chain and loads the default masks and gains
//  bubbles in the chain collapse under bus_stall; sample_stall rises only
//  when every stage holds a frame and the output transfer is held off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crosspoint_sum_mixer_core import csm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  // frame input
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_port0,
  input  logic signed [SAMPLE_BITS-1:0] sample_port1,
  input  logic signed [SAMPLE_BITS-1:0] sample_port2,
  input  logic signed [SAMPLE_BITS-1:0] sample_port3,
  input  logic signed [SAMPLE_BITS-1:0] sample_port4,
  input  logic signed [SAMPLE_BITS-1:0] sample_port5,
  input  logic signed [SAMPLE_BITS-1:0] sample_port6,
  input  logic signed [SAMPLE_BITS-1:0] sample_port7,
  input  logic                     block_end_in,
  // bus output
  output logic                     bus_valid,
  input  logic                     bus_stall,
  output logic signed [SAMPLE_BITS-1:0] bus_one,
  output logic signed [SAMPLE_BITS-1:0] bus_two,
  output logic signed [SAMPLE_BITS-1:0] bus_three,
  output logic signed [SAMPLE_BITS-1:0] bus_four,
  output logic [BUS_COUNT-1:0]     clip_flags,
  output logic                     block_end_out
);

  // configuration registers
  logic [31:0]         bus_masks;
  logic [CFG_BITS-1:0] gains_low_ports;
  logic [CFG_BITS-1:0] gains_high_ports;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_masks        <= BUS_MASKS_RESET;
      gains_low_ports  <= GAINS_RESET;
      gains_high_ports <= GAINS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BUS_MASKS:  bus_masks        <= cfg_data[31:0];
        REG_GAINS_LOW:  gains_low_ports  <= cfg_data;
        REG_GAINS_HIGH: gains_high_ports <= cfg_data;
        default: ;  // index outside the register list: write dropped
      endcase
    end
  end

  // stage k feeds cell k; stage PORT_COUNT feeds the output stage
  csm_stage_t           stage [PORT_COUNT+1];
  logic [PORT_COUNT:0]  stage_valid;
  logic [PORT_COUNT:0]  adv;   // adv[k]: register fed by stage k may load

  // frame entering the chain: accumulators start at the rounding offset
  always_comb begin
    stage[0].samples[0] = sample_port0;
    stage[0].samples[1] = sample_port1;
    stage[0].samples[2] = sample_port2;
    stage[0].samples[3] = sample_port3;
    stage[0].samples[4] = sample_port4;
    stage[0].samples[5] = sample_port5;
    stage[0].samples[6] = sample_port6;
    stage[0].samples[7] = sample_port7;
    for (int b = 0; b < BUS_COUNT; b++) begin
      stage[0].acc[b] = ROUND_HALF;
    end
    stage[0].prod      = '0;
    stage[0].prod_mask = '0;
    stage[0].block_end = block_end_in;
  end
  assign stage_valid[0] = sample_valid;

  // a register loads when it is empty or its content moves on this cycle
  always_comb begin
    adv[PORT_COUNT] = !bus_valid || !bus_stall;
    for (int k = PORT_COUNT - 1; k >= 0; k--) begin
      adv[k] = !stage_valid[k+1] || adv[k+1];
    end
  end
  assign sample_stall = !adv[0];

  // one cell per port
  for (genvar p = 0; p < PORT_COUNT; p++) begin : g_cell
    logic [GAIN_BITS-1:0] gain;
    if (p < 4) begin : g_lo
      assign gain = gains_low_ports[GAIN_BITS*p +: GAIN_BITS];
    end else begin : g_hi
      assign gain = gains_high_ports[GAIN_BITS*(p-4) +: GAIN_BITS];
    end

    csm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv[p]),
      .valid_in  (stage_valid[p]),
      .stage_in  (stage[p]),
      .sample    (stage[p].samples[p]),
      .gain      (gain),
      .mask      (bus_masks[MASK_BITS*p +: BUS_COUNT]),
      .valid_out (stage_valid[p+1]),
      .stage_out (stage[p+1])
    );
  end

  // last product, rounding, saturation and the output register
  logic [BUS_COUNT-1:0][SAMPLE_BITS-1:0] bus_val;

  csm_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv[PORT_COUNT]),
    .valid_in  (stage_valid[PORT_COUNT]),
    .stage_in  (stage[PORT_COUNT]),
    .valid_out (bus_valid),
    .bus_val   (bus_val),
    .clip      (clip_flags),
    .block_end (block_end_out)
  );

  assign bus_one   = bus_val[0];
  assign bus_two   = bus_val[1];
  assign bus_three = bus_val[2];
  assign bus_four  = bus_val[3];

  // input is held off only when the whole chain and the output are full
  `CSM_ASSERT(stall_full_a, sample_stall |-> (&stage_valid[PORT_COUNT:1]) && bus_valid && bus_stall)

  // with the output taken, the chain never pushes back on the source
  `CSM_ASSERT(no_stall_free_a, !bus_stall |-> !sample_stall)

endmodule

>>> verif/crosspoint_sum_mixer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crosspoint_sum_mixer_core_tb
// self-checking bench for the eight-port, four-bus crosspoint mixer: frames
// go in through a bursty sender, bus sums come back under a shifting stall
// pattern, and each result is checked against a bit-exact mix computed from
// a shadow copy of the masks and gains
// ----------------------------------------------------------------------------
module crosspoint_sum_mixer_core_tb;
  import csm_pkg::*;

  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 9;
  // one stage per port cell plus the output register
  localparam int PIPE_DEPTH       = PORT_COUNT + 1;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int FRAMES_PER_PHASE = 150;
  localparam int RANDOM_SETTINGS  = 6;
  localparam int PRINT_LIMIT      = 30;

  // index past the register list, written in two settings to show it is ignored
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(3);

  // one input frame and one bus result, both at port widths
  typedef struct packed {
    logic [PORT_COUNT-1:0][SAMPLE_BITS-1:0] smp;
    logic                                   blk;
  } frame_t;

  typedef struct packed {
    logic [BUS_COUNT-1:0][SAMPLE_BITS-1:0] sum;
    logic [BUS_COUNT-1:0]                  clip;
    logic                                  blk;
  } mix_t;

  // receiver stall styles, each held for a random stretch of cycles
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_RANDOM,
    FLOW_PERIODIC,
    FLOW_BURSTY
  } flow_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(CLK_HALF) clk = ~clk;

  // block inputs, all known from time zero
  logic                                   cfg_write    = 1'b0;
  logic [CFG_IDX_BITS-1:0]                cfg_index    = '0;
  logic [CFG_BITS-1:0]                    cfg_data     = '0;
  logic                                   sample_valid = 1'b0;
  logic [PORT_COUNT-1:0][SAMPLE_BITS-1:0] port_drv     = '0;
  logic                                   block_end_drv = 1'b0;
  logic                                   bus_stall    = 1'b0;

  // block outputs
  logic                          sample_stall;
  logic                          bus_valid;
  logic signed [SAMPLE_BITS-1:0] bus_one;
  logic signed [SAMPLE_BITS-1:0] bus_two;
  logic signed [SAMPLE_BITS-1:0] bus_three;
  logic signed [SAMPLE_BITS-1:0] bus_four;
  logic [BUS_COUNT-1:0]          clip_flags;
  logic                          block_end_out;

  crosspoint_sum_mixer_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample_port0  (port_drv[0]),
    .sample_port1  (port_drv[1]),
    .sample_port2  (port_drv[2]),
    .sample_port3  (port_drv[3]),
    .sample_port4  (port_drv[4]),
    .sample_port5  (port_drv[5]),
    .sample_port6  (port_drv[6]),
    .sample_port7  (port_drv[7]),
    .block_end_in  (block_end_drv),
    .bus_valid     (bus_valid),
    .bus_stall     (bus_stall),
    .bus_one       (bus_one),
    .bus_two       (bus_two),
    .bus_three     (bus_three),
    .bus_four      (bus_four),
    .clip_flags    (clip_flags),
    .block_end_out (block_end_out)
  );

  // shadow of the configuration registers, starting at their reset values
  logic [31:0]         mask_word = BUS_MASKS_RESET;
  logic [CFG_BITS-1:0] gains_lo  = GAINS_RESET;
  logic [CFG_BITS-1:0] gains_hi  = GAINS_RESET;

  // frames waiting for the sender, and bus results owed by the block
  frame_t frames_to_send[$];
  mix_t   bus_frames_due[$];

  // run statistics
  int mismatch_count  = 0;
  int frames_sent     = 0;
  int results_checked = 0;
  int clipped_buses   = 0;
  int block_ends_seen = 0;
  int settings_loaded = 0;
  int cycle_count     = 0;

  // ---------------------------------------------------------------------------
  // bit-exact mix of one frame under the shadow configuration
  // products are exact, summed wide, rounded half up to q1.23, then clamped
  // ---------------------------------------------------------------------------
  function automatic mix_t mix_frame(input frame_t f);
    longint               acc [BUS_COUNT];
    longint               prod;
    longint               q;
    longint               hi;
    longint               lo;
    logic [MASK_BITS-1:0] sel;
    logic [GAIN_BITS-1:0] g;
    mix_t                 r;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    for (int b = 0; b < BUS_COUNT; b++) acc[b] = 0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      sel = mask_word[MASK_BITS*p +: MASK_BITS];
      if (p < 4) g = gains_lo[GAIN_BITS*p +: GAIN_BITS];
      else g = gains_hi[GAIN_BITS*(p-4) +: GAIN_BITS];
      // signed sample times unsigned gain
      prod = longint'($signed(f.smp[p])) * longint'(g);
      for (int b = 0; b < BUS_COUNT; b++)
        if (sel[b]) acc[b] += prod;
    end
    r.clip = '0;
    for (int b = 0; b < BUS_COUNT; b++) begin
      // arithmetic shift gives the floor, so this is round half up
      q = (acc[b] + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
      if (q > hi) begin
        q = hi;
        r.clip[b] = 1'b1;
      end else if (q < lo) begin
        q = lo;
        r.clip[b] = 1'b1;
      end
      r.sum[b] = SAMPLE_BITS'(q);
    end
    r.blk = f.blk;
    return r;
  endfunction

  // one printed line per mismatch, capped, every one counted
  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch at result %0d, %s: got %h, want %h",
               results_checked, field, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // random content helpers
  // ---------------------------------------------------------------------------

  // mix of full-range, mid-level, rail and near-zero samples so that both
  // clipped and unclipped sums show up under large gains
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_BITS'($urandom());
      4, 5, 6:    return SAMPLE_BITS'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      7: begin
        case ($urandom_range(0, 3))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:    return SAMPLE_BITS'(int'($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_BITS'(1 << GAIN_FRAC);
      3, 4:    return GAIN_BITS'($urandom_range(0, 1 << GAIN_FRAC));
      default: return GAIN_BITS'($urandom());
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int p = 0; p < PORT_COUNT; p++) f.smp[p] = rand_sample();
    f.blk = ($urandom_range(0, 7) == 0);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration and phase control, called from the stimulus process only
  // ---------------------------------------------------------------------------

  // hold cfg_write for one edge; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_BUS_MASKS:  mask_word = data[31:0];
      REG_GAINS_LOW:  gains_lo  = data;
      REG_GAINS_HIGH: gains_hi  = data;
      default: ;
    endcase
  endtask

  // new masks and gains; the upper half of the mask write carries junk that
  // the block must drop, and optionally a stray write to the unused index
  task automatic load_setting(input logic [31:0] masks, input logic [CFG_BITS-1:0] lo_g,
                              input logic [CFG_BITS-1:0] hi_g, input bit stray);
    write_reg(REG_BUS_MASKS, {$urandom(), masks});
    write_reg(REG_GAINS_LOW, lo_g);
    if (stray) write_reg(REG_UNUSED, {$urandom(), $urandom()});
    write_reg(REG_GAINS_HIGH, hi_g);
    cfg_write <= 1'b0;
    settings_loaded++;
  endtask

  // sender idle and every owed result delivered; judged mid-cycle once the
  // sender and receiver have settled, then back on a rising edge
  task automatic wait_idle();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || sample_valid || bus_frames_due.size() != 0);
    @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) frames_to_send.push_back(rand_frame());
  endtask

  // all ports at one value
  task automatic queue_flat(input logic [SAMPLE_BITS-1:0] v, input logic blk);
    frame_t f;
    for (int p = 0; p < PORT_COUNT; p++) f.smp[p] = v;
    f.blk = blk;
    frames_to_send.push_back(f);
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length separated by random gaps, sometimes
  // long runs back to back; a held frame stays put until its transfer
  // ---------------------------------------------------------------------------
  int     burst_left = 1;
  int     gap_left   = 0;
  frame_t cur_frame  = '0;

  always @(posedge clk) begin : send_frames
    frame_t nxt;
    logic   held;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      held = sample_valid && sample_stall;
      // transfer of the frame on the ports at this edge
      if (sample_valid && !sample_stall) begin
        bus_frames_due.push_back(mix_frame(cur_frame));
        frames_sent++;
      end
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_valid <= 1'b0;
        end else if (frames_to_send.size() > 0) begin
          nxt = frames_to_send.pop_front();
          cur_frame = nxt;
          port_drv      <= nxt.smp;
          block_end_drv <= nxt.blk;
          sample_valid  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(13, 30);
              default:    gap_left = $urandom_range(1, 12);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each bus transfer against the oldest owed result and
  // picks its stall for the next edge from the current flow style
  // ---------------------------------------------------------------------------
  flow_t flow_mode  = FLOW_FREE;
  int    flow_run   = 0;
  int    flow_phase = 0;
  int    stall_hold = 0;

  always @(posedge clk) begin : check_buses
    mix_t                                  want;
    logic [BUS_COUNT-1:0][SAMPLE_BITS-1:0] got;
    if (!rst) begin
      if (bus_valid && !bus_stall) begin
        if (bus_frames_due.size() == 0) begin
          report_mismatch("bus transfer with nothing owed", 64'(bus_one), 64'd0);
        end else begin
          want = bus_frames_due.pop_front();
          got  = {bus_four, bus_three, bus_two, bus_one};
          for (int b = 0; b < BUS_COUNT; b++)
            if (got[b] !== want.sum[b])
              report_mismatch($sformatf("bus %0d sum", b + 1), 64'(got[b]), 64'(want.sum[b]));
          if (clip_flags !== want.clip)
            report_mismatch("clip flags", 64'(clip_flags), 64'(want.clip));
          if (block_end_out !== want.blk)
            report_mismatch("block end", 64'(block_end_out), 64'(want.blk));
          for (int b = 0; b < BUS_COUNT; b++) clipped_buses += want.clip[b];
          block_ends_seen += want.blk;
          results_checked++;
        end
      end

      // new stall style after each run of random length
      if (flow_run == 0) begin
        case ($urandom_range(0, 3))
          0:       flow_mode = FLOW_FREE;
          1:       flow_mode = FLOW_RANDOM;
          2:       flow_mode = FLOW_PERIODIC;
          default: flow_mode = FLOW_BURSTY;
        endcase
        flow_run = $urandom_range(40, 400);
      end else begin
        flow_run--;
      end
      flow_phase++;

      case (flow_mode)
        FLOW_FREE:     bus_stall <= 1'b0;
        FLOW_RANDOM:   bus_stall <= ($urandom_range(0, 2) == 0);
        // stalled six tenths of the time in a repeating pattern, lets the chain fill up
        FLOW_PERIODIC: bus_stall <= ((flow_phase % 10) < 6);
        default: begin
          if (stall_hold > 0) begin
            stall_hold--;
            bus_stall <= 1'b1;
          end else if ($urandom_range(0, 19) == 0) begin
            stall_hold = $urandom_range(3, 15);
            bus_stall <= 1'b1;
          end else begin
            bus_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results owed",
               cycle_count, bus_frames_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed frames under reset values and chosen settings, then
  // random settings with random frames; every setting change happens with
  // the block drained
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    frame_t              f;
    logic [31:0]         m;
    logic [CFG_BITS-1:0] glo;
    logic [CFG_BITS-1:0] ghi;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset values: every port to bus one at unity gain
    queue_flat('0, 1'b0);
    queue_flat(SAT_MAX, 1'b1);     // eight full-scale ports clip high
    queue_flat(SAT_MIN, 1'b0);     // and low
    queue_flat('1, 1'b1);          // minus one lsb on every port
    f = '0;
    f.smp[0] = SAT_MAX;            // one port alone reaches full scale unclipped
    frames_to_send.push_back(f);
    for (int p = 0; p < PORT_COUNT; p++) f.smp[p] = p[0] ? SAT_MIN : SAT_MAX;
    f.blk = 1'b1;                  // opposite rails nearly cancel
    frames_to_send.push_back(f);
    queue_random(FRAMES_PER_PHASE);
    wait_idle();

    // one port per bus, two empty masks, one port on every bus, one on two;
    // gains picked for rounding ties and for a near-16x clip on bus four
    load_setting(32'h50F0_8421, 64'hFFFF_0001_0800_0800, 64'h0800_FFFF_1000_FFFF, 1'b0);
    f = '0;
    f.smp[0] = SAMPLE_BITS'(1);    // half an lsb rounds up
    f.smp[1] = SAMPLE_BITS'(3);    // one and a half rounds up
    f.smp[2] = SAMPLE_BITS'(2048); // exactly one half after the tiny gain
    frames_to_send.push_back(f);
    f.smp[0] = SAMPLE_BITS'(-1);   // minus a half rounds up to zero
    f.smp[1] = SAMPLE_BITS'(-3);   // minus one and a half rounds to minus one
    f.smp[2] = SAMPLE_BITS'(-2049);
    f.blk    = 1'b1;
    frames_to_send.push_back(f);
    f = '0;
    f.smp[3] = SAT_MAX;            // clips bus four
    f.smp[4] = SAT_MAX;            // empty mask, must add nothing
    f.smp[6] = SAT_MIN;            // empty mask as well
    frames_to_send.push_back(f);
    f.smp[3] = SAT_MIN;
    f.smp[5] = SAT_MAX;            // port on all buses at unity
    f.smp[7] = SAT_MIN;
    frames_to_send.push_back(f);
    queue_random(FRAMES_PER_PHASE);
    wait_idle();

    // every port on every bus at the largest gain
    load_setting('1, '1, '1, 1'b0);
    queue_flat(SAT_MAX, 1'b0);
    queue_flat(SAT_MIN, 1'b1);
    queue_flat(SAMPLE_BITS'(1), 1'b0);
    queue_random(FRAMES_PER_PHASE);
    wait_idle();

    // every mask empty: all buses silent whatever comes in
    load_setting('0, '1, '1, 1'b0);
    queue_flat(SAT_MIN, 1'b1);
    queue_random(FRAMES_PER_PHASE / 2);
    wait_idle();

    // full routing with zero gain, plus a write to the unused index
    load_setting('1, '0, '0, 1'b1);
    queue_flat(SAT_MAX, 1'b0);
    queue_random(FRAMES_PER_PHASE / 2);
    wait_idle();

    // random settings; the first one pauses the sender halfway to drain
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        m[MASK_BITS*p +: MASK_BITS] =
          ($urandom_range(0, 4) == 0) ? '0 : MASK_BITS'($urandom_range(1, 15));
        if (p < 4) glo[GAIN_BITS*p +: GAIN_BITS] = rand_gain();
        else ghi[GAIN_BITS*(p-4) +: GAIN_BITS] = rand_gain();
      end
      load_setting(m, glo, ghi, (s == RANDOM_SETTINGS - 1));
      if (s == 0) begin
        queue_random(FRAMES_PER_PHASE / 2);
        wait_idle();
        queue_random(FRAMES_PER_PHASE / 2);
      end else begin
        queue_random(FRAMES_PER_PHASE);
      end
      wait_idle();
    end

    // back to reset values to finish
    load_setting(BUS_MASKS_RESET, GAINS_RESET, GAINS_RESET, 1'b0);
    queue_random(FRAMES_PER_PHASE);
    wait_idle();

    // anything arriving now is unowed and gets flagged by the receiver
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    $display("sent %0d frames under %0d register settings, checked %0d bus results",
             frames_sent, settings_loaded, results_checked);
    $display("saw %0d clipped bus sums and %0d block ends, %0d mismatches",
             clipped_buses, block_ends_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
